// File: design/mono_page_framebuffer_window_writer_defines.svh
// Assertion macros for the framebuffer window writer.
`ifndef MONO_PAGE_FRAMEBUFFER_WINDOW_WRITER_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_WINDOW_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define MPFW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framebuffer window writer: same-cycle check failed");
// Next-cycle implication, disabled in reset.
`define MPFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framebuffer window writer: next-cycle check failed");
`else
`define MPFW_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MPFW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/mpfw_pkg.sv
// Shared types and constants of the framebuffer window writer.
`timescale 1ns / 1ps
`default_nettype none

package mpfw_pkg;

   localparam int FULL_ADDR_W = 12;

   localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
   localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_DATA    = 1'b1;

   localparam logic [1:0] CSR_WINDOW_LEFT   = 2'd0;
   localparam logic [1:0] CSR_WINDOW_TOP    = 2'd1;
   localparam logic [1:0] CSR_WINDOW_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_WINDOW_HEIGHT = 2'd3;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic        call_end;
   } req_data_type;

   typedef struct packed {
      logic        item_kind;
      logic [63:0] payload;
      logic [3:0]  byte_count;
      logic        last_of_run;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: design/mono_page_framebuffer_window_writer.sv
// Top level: page-mode 1bpp framebuffer window writer with command and data stream.
// A pixel that ends no row is accepted (ST_IDLE), then read-modify-written (ST_RMW).
// A row-ending pixel then emits the six window command bytes and reads back the window's
// bytes of that page in data words of up to eight bytes; the result side can stall either.
// Reset: synchronous; clears control state, then sweeps the frame memory to zero,
// one byte per cycle, all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 by default).
`timescale 1ns / 1ps
`default_nettype none
`include "mono_page_framebuffer_window_writer_defines.svh"

module mono_page_framebuffer_window_writer #(
   parameter int PANEL_WIDTH   = 128,
   parameter int PANEL_HEIGHT  = 64,
   parameter int COLUMN_OFFSET = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire mpfw_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mpfw_pkg::rsp_data_type rsp_data,
   input  wire                   csr_wr_en,
   input  wire  [1:0]            csr_index,
   input  wire  [7:0]            csr_wdata
);

   import mpfw_pkg::*;

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   // Controller states, one-hot.
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,   // zero sweep of the frame memory after reset
      ST_IDLE  = 7'b0000010,   // wait for a pixel
      ST_RMW   = 7'b0000100,   // read data back, write the updated byte
      ST_CMD   = 7'b0001000,   // emit the six window command bytes
      ST_DRD   = 7'b0010000,   // issue byte reads for one data word
      ST_DCAP  = 7'b0100000,   // last byte of the word lands
      ST_DPUT  = 7'b1000000    // hand the packed word to the output register
   } state_type;

   // Command byte sequence of one row end.
   typedef enum logic [2:0] {
      STEP_COL_CMD,
      STEP_COL_START,
      STEP_COL_END,
      STEP_PAGE_CMD,
      STEP_PAGE_START,
      STEP_PAGE_END
   } cmd_step_type;

   // Byte address of column col in page pg.
   function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] pg,
                                                   input logic [7:0] col);
      logic [FULL_ADDR_W-1:0] full;
      full = FULL_ADDR_W'(pg) * FULL_ADDR_W'(PANEL_WIDTH) + FULL_ADDR_W'(col);
      return full[ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type        state_ff,      state_in;
   logic [ADDR_W-1:0] clr_addr_ff,  clr_addr_in;
   logic [6:0]       win_left_ff,   win_left_in;
   logic [5:0]       win_top_ff,    win_top_in;
   logic [7:0]       win_width_ff,  win_width_in;
   logic [6:0]       win_height_ff, win_height_in;
   logic [7:0]       col_ff,        col_in;
   logic [6:0]       row_ff,        row_in;
   logic             ignore_ff,     ignore_in;
   cmd_step_type     cmd_step_ff,   cmd_step_in;
   logic [2:0]       rd_lane_ff,    rd_lane_in;
   logic             cap_v_ff,      cap_v_in;
   logic [63:0]      word_ff,       word_in;
   logic             rsp_valid_ff,  rsp_valid_in;

   // Payload registers, no reset.
   logic             lit_ff,        lit_in;
   logic [2:0]       bit_ff,        bit_in;
   logic [ADDR_W-1:0] addr_ff,      addr_in;
   logic [2:0]       page_ff,       page_in;
   logic             row_end_ff,    row_end_in;
   logic [7:0]       rd_col_ff,     rd_col_in;
   logic [2:0]       cap_lane_ff,   cap_lane_in;
   logic [3:0]       word_cnt_ff,   word_cnt_in;
   logic             band_last_ff,  band_last_in;
   rsp_data_type     rsp_data_ff,   rsp_data_in;

   // Frame memory, one byte per column per page.
   logic [7:0]        frame_mem [STORE_BYTES];
   logic [7:0]        mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   // ---------------------------------------------------------------------------
   // Window clipping and cursor arithmetic
   // ---------------------------------------------------------------------------
   logic [8:0]        left9, w9, room_w, x1_9, col_next9;
   logic [6:0]        top7, h7, room_h, row_next7;
   logic [7:0]        pix_x;
   logic [5:0]        pix_y;
   logic [ADDR_W-1:0] pix_addr;
   logic              row_end, win_done;

   always_comb begin
      // Clamp the start to the panel, force a nonzero size, clip to the edge.
      left9 = {2'b00, win_left_ff};
      if (left9 > 9'(PANEL_WIDTH - 1)) begin
         left9 = 9'(PANEL_WIDTH - 1);
      end
      top7 = {1'b0, win_top_ff};
      if (top7 > 7'(PANEL_HEIGHT - 1)) begin
         top7 = 7'(PANEL_HEIGHT - 1);
      end
      w9 = (win_width_ff == 8'd0) ? 9'd1 : {1'b0, win_width_ff};
      room_w = 9'(PANEL_WIDTH) - left9;
      if (w9 > room_w) begin
         w9 = room_w;
      end
      h7 = (win_height_ff == 7'd0) ? 7'd1 : win_height_ff;
      room_h = 7'(PANEL_HEIGHT) - top7;
      if (h7 > room_h) begin
         h7 = room_h;
      end
      x1_9 = left9 + w9 - 9'd1;

      // The cursor always stays inside the clipped window, so the pixel is on panel.
      pix_x     = 8'(left9 + 9'(col_ff));
      pix_y     = 6'(top7 + row_ff);
      pix_addr  = store_addr(pix_y[5:3], pix_x);
      col_next9 = 9'(col_ff) + 9'd1;
      row_end   = (col_next9 >= w9);
      row_next7 = row_ff + 7'd1;
      win_done  = (row_next7 >= h7);
   end

   // ---------------------------------------------------------------------------
   // Controller
   // ---------------------------------------------------------------------------
   logic req_fire;
   logic out_free;
   logic rsp_load;
   logic word_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      win_left_in   = win_left_ff;
      win_top_in    = win_top_ff;
      win_width_in  = win_width_ff;
      win_height_in = win_height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      ignore_in     = ignore_ff;
      cmd_step_in   = cmd_step_ff;
      rd_lane_in    = rd_lane_ff;
      cap_v_in      = 1'b0;
      word_in       = word_ff;
      lit_in        = lit_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      page_in       = page_ff;
      row_end_in    = row_end_ff;
      rd_col_in     = rd_col_ff;
      cap_lane_in   = cap_lane_ff;
      word_cnt_in   = word_cnt_ff;
      band_last_in  = band_last_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      word_done     = 1'b0;

      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = 8'h00;
      mem_re    = 1'b0;
      mem_raddr = pix_addr;

      // Drop each returned byte into its lane of the word being packed.
      if (cap_v_ff) begin
         word_in[{cap_lane_ff, 3'b000} +: 8] = mem_rdata_ff;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (ignore_ff) begin
                  // Swallow pixels after the window completed, until the call ends.
                  if (req_data.call_end) begin
                     ignore_in = 1'b0;
                  end
               end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = pix_addr;
                  lit_in     = |req_data.pixel_color;
                  bit_in     = pix_y[2:0];
                  addr_in    = pix_addr;
                  page_in    = pix_y[5:3];
                  row_end_in = row_end;
                  state_in   = ST_RMW;
                  if (row_end) begin
                     col_in = 8'd0;
                     if (win_done) begin
                        row_in    = 7'd0;
                        ignore_in = 1'b1;
                     end else begin
                        row_in = row_next7;
                     end
                  end else begin
                     col_in = col_next9[7:0];
                  end
                  if (req_data.call_end) begin
                     ignore_in = 1'b0;
                  end
               end
            end
         end
         ST_RMW: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = lit_ff ? (mem_rdata_ff | (8'h01 << bit_ff))
                               : (mem_rdata_ff & ~(8'h01 << bit_ff));
            if (row_end_ff) begin
               cmd_step_in = STEP_COL_CMD;
               state_in    = ST_CMD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CMD: begin
            if (out_free) begin
               rsp_load                = 1'b1;
               rsp_data_in.item_kind   = KIND_COMMAND;
               rsp_data_in.byte_count  = 4'd1;
               rsp_data_in.last_of_run = 1'b0;
               rsp_data_in.payload     = 64'd0;
               cmd_step_in = cmd_step_type'(cmd_step_ff + 3'd1);
               unique case (cmd_step_ff)
                  STEP_COL_CMD:    rsp_data_in.payload[7:0] = CMD_COLUMN_RANGE;
                  STEP_COL_START:  rsp_data_in.payload[7:0] =
                                      8'(left9 + 9'(COLUMN_OFFSET));
                  STEP_COL_END:    rsp_data_in.payload[7:0] =
                                      8'(x1_9 + 9'(COLUMN_OFFSET));
                  STEP_PAGE_CMD:   rsp_data_in.payload[7:0] = CMD_PAGE_RANGE;
                  STEP_PAGE_START: rsp_data_in.payload[7:0] = {5'd0, page_ff};
                  STEP_PAGE_END: begin
                     rsp_data_in.payload[7:0] = {5'd0, page_ff};
                     rd_col_in  = left9[7:0];
                     rd_lane_in = 3'd0;
                     word_in    = 64'd0;
                     state_in   = ST_DRD;
                  end
                  default: rsp_data_in.payload[7:0] = 8'h00;
               endcase
            end
         end
         ST_DRD: begin
            // Stream one byte read per cycle; each byte is captured in the cycle after its read.
            mem_re      = 1'b1;
            mem_raddr   = store_addr(page_ff, rd_col_ff);
            cap_v_in    = 1'b1;
            cap_lane_in = rd_lane_ff;
            rd_col_in   = rd_col_ff + 8'd1;
            rd_lane_in  = rd_lane_ff + 3'd1;
            word_done   = (rd_col_ff == x1_9[7:0]) || (&rd_lane_ff);
            if (word_done) begin
               word_cnt_in  = 4'(rd_lane_ff) + 4'd1;
               band_last_in = (rd_col_ff == x1_9[7:0]);
               state_in     = ST_DCAP;
            end
         end
         ST_DCAP: begin
            state_in = ST_DPUT;
         end
         ST_DPUT: begin
            if (out_free) begin
               rsp_load                = 1'b1;
               rsp_data_in.item_kind   = KIND_DATA;
               rsp_data_in.payload     = word_ff;
               rsp_data_in.byte_count  = word_cnt_ff;
               rsp_data_in.last_of_run = band_last_ff;
               word_in    = 64'd0;
               rd_lane_in = 3'd0;
               state_in   = band_last_ff ? ST_IDLE : ST_DRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes move the cursor home; the ignore flag is kept.
      if (csr_wr_en) begin
         col_in = 8'd0;
         row_in = 7'd0;
         unique case (csr_index)
            CSR_WINDOW_LEFT:   win_left_in   = csr_wdata[6:0];
            CSR_WINDOW_TOP:    win_top_in    = csr_wdata[5:0];
            CSR_WINDOW_WIDTH:  win_width_in  = csr_wdata;
            CSR_WINDOW_HEIGHT: win_height_in = csr_wdata[6:0];
            default:           win_left_in   = win_left_ff;
         endcase
      end

      // Output register: load a new result or retire the accepted one.
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         win_left_ff   <= 7'd0;
         win_top_ff    <= 6'd0;
         win_width_ff  <= 8'd128;
         win_height_ff <= 7'd64;
         col_ff        <= 8'd0;
         row_ff        <= 7'd0;
         ignore_ff     <= 1'b0;
         cmd_step_ff   <= STEP_COL_CMD;
         rd_lane_ff    <= 3'd0;
         cap_v_ff      <= 1'b0;
         word_ff       <= 64'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         win_left_ff   <= win_left_in;
         win_top_ff    <= win_top_in;
         win_width_ff  <= win_width_in;
         win_height_ff <= win_height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         ignore_ff     <= ignore_in;
         cmd_step_ff   <= cmd_step_in;
         rd_lane_ff    <= rd_lane_in;
         cap_v_ff      <= cap_v_in;
         word_ff       <= word_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff       <= lit_in;
      bit_ff       <= bit_in;
      addr_ff      <= addr_in;
      page_ff      <= page_in;
      row_end_ff   <= row_end_in;
      rd_col_ff    <= rd_col_in;
      cap_lane_ff  <= cap_lane_in;
      word_cnt_ff  <= word_cnt_in;
      band_last_ff <= band_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Single-port-style frame memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= frame_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   logic rsp_last_valid;

   assign rsp_last_valid = rsp_valid_ff && rsp_data_ff.last_of_run;

   `MPFW_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_load, out_free)
   `MPFW_ASSERT_IMPLY(a_cap_after_read, clock, reset, cap_v_ff, $past(mem_re))
   `MPFW_ASSERT_IMPLY(a_last_is_data, clock, reset, rsp_last_valid, rsp_data_ff.item_kind == KIND_DATA)
   `MPFW_ASSERT_NEXT(a_pixel_to_rmw, clock, reset, req_fire && !ignore_ff, state_ff == ST_RMW)

endmodule

`default_nettype wire
